// ===== rtl/core/sps_pkg.sv =====
// Package with the shared types, constants and beat tables of the stepper phase sequencer.
`default_nettype none

package sps_pkg;

    // Command codes.
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_START = 2'd1;
    localparam logic [1:0] CMD_STOP  = 2'd2;

    // Drive mode codes.
    localparam logic [1:0] MODE_HALF = 2'd0;
    localparam logic [1:0] MODE_WAVE = 2'd1;
    localparam logic [1:0] MODE_TWO  = 2'd2;
    localparam logic [1:0] MODE_NONE = 2'd3;

    // Default width of the sequence counter.
    localparam int SEQ_COUNT_WIDTH_DEF = 16;

    // Field widths.
    localparam int ANGLE_W = 16;
    localparam int DELAY_W = 8;
    localparam int BEAT_W  = 3;

    // 64*angle/45 is computed as (angle * RECIP) >> RECIP_SHIFT, exact for any 16-bit angle.
    localparam int RECIP_W     = 23;
    localparam int RECIP_SHIFT = 22;
    localparam logic [RECIP_W-1:0] RECIP = 23'd5965233;
    localparam int QUOT_W      = 17;

    // Reset value of the beat delay register.
    localparam logic [DELAY_W-1:0] DELAY_RESET = 8'd2;

    // Input request.
    typedef struct packed {
        logic [1:0]         cmd;
        logic               direction;
        logic [1:0]         drive_mode;
        logic [ANGLE_W-1:0] angle_deg;
    } sps_in_t;

    // Result item.
    typedef struct packed {
        logic [3:0] coils;
        logic       busy_res;
        logic       done_res;
        logic       rejected;
    } sps_out_t;

    // Beat tables in forward order, bit0 is coil A.
    localparam logic [3:0] HALF_BEATS [8] = '{4'h1, 4'h3, 4'h2, 4'h6, 4'h4, 4'hC, 4'h8, 4'h9};
    localparam logic [3:0] WAVE_BEATS [4] = '{4'h1, 4'h2, 4'h4, 4'h8};
    localparam logic [3:0] TWO_BEATS  [4] = '{4'h9, 4'h3, 4'h6, 4'hC};

    // Coil pattern for a position in playing order; reverse mirrors the position.
    function automatic logic [3:0] beat_pattern(
        input logic [1:0]        mode,
        input logic              dir,
        input logic [BEAT_W-1:0] pos
    );
        logic [BEAT_W-1:0] k8;
        logic [1:0]        k4;
        logic [3:0]        pat;
        k8 = dir ? pos : (3'd7 - pos);
        k4 = dir ? pos[1:0] : (2'd3 - pos[1:0]);
        unique case (mode)
            MODE_HALF: pat = HALF_BEATS[k8];
            MODE_WAVE: pat = WAVE_BEATS[k4];
            default:   pat = TWO_BEATS[k4];
        endcase
        return pat;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/stepper_phase_sequencer.sv =====
// Top level of the unipolar stepper phase sequencer.
`default_nettype none

// Plays half-step, wave or two-phase beat sequences on four coils A..D. Each
// request is a tick, a start or a stop and yields exactly one result: the coil
// drive and busy, done and rejected flags after that request. A request is
// taken in every cycle in which no result waits or the waiting result is
// taken; its result appears in the output register on the next clock edge.
// The sequence count floor(64*angle/45) comes from one 16x23 constant multiply
// in the request cycle. The beat delay register holds the number of ticks each
// beat is held, zero meaning one.
module stepper_phase_sequencer #(
    parameter int SEQ_COUNT_WIDTH = sps_pkg::SEQ_COUNT_WIDTH_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_we,
    input  wire logic [sps_pkg::DELAY_W-1:0]   cfg_wdata,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire sps_pkg::sps_in_t              s_data,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output sps_pkg::sps_out_t                  m_data
);

    import sps_pkg::*;

    localparam int CW     = SEQ_COUNT_WIDTH;
    localparam int EXW    = (CW > QUOT_W) ? CW : QUOT_W;
    localparam int PROD_W = ANGLE_W + RECIP_W;

    // State registers.
    logic [DELAY_W-1:0] delay_reg;
    logic [3:0]         coil_reg,  coil_next;
    logic               moving_reg, moving_next;
    logic               dir_reg,   dir_next;
    logic [1:0]         mode_reg,  mode_next;
    logic [BEAT_W-1:0]  beat_reg,  beat_next;
    logic [CW-1:0]      seq_reg,   seq_next;
    logic [DELAY_W-1:0] timer_reg, timer_next;

    // Output stage.
    logic               m_valid_reg;
    sps_out_t           m_data_reg;
    sps_out_t           res_next;

    logic               accept;
    logic               done;
    logic               rej;
    logic [PROD_W-1:0]  product;
    logic [QUOT_W-1:0]  quot;
    logic [EXW-1:0]     quot_ext;
    logic [EXW-1:0]     max_ext;
    logic [CW-1:0]      count;
    logic [DELAY_W-1:0] held;
    logic [DELAY_W-1:0] timer_dec;
    logic               wrap;
    logic [CW-1:0]      seq_dec;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Sequence count from the angle, saturated to the counter width.
    assign product  = PROD_W'(s_data.angle_deg) * PROD_W'(RECIP);
    assign quot     = product[RECIP_SHIFT +: QUOT_W];
    assign quot_ext = EXW'(quot);
    assign max_ext  = EXW'({CW{1'b1}});
    assign count    = (quot_ext > max_ext) ? {CW{1'b1}} : quot_ext[CW-1:0];

    // Ticks per beat, zero counts as one.
    assign held = (delay_reg == '0) ? DELAY_W'(1) : delay_reg;

    // Tick path helpers.
    assign timer_dec = (timer_reg != '0) ? timer_reg - DELAY_W'(1) : timer_reg;
    assign wrap      = (mode_reg == MODE_HALF) ? (beat_reg == 3'd7) : (beat_reg[1:0] == 2'd3);
    assign seq_dec   = (wrap && seq_reg != '0) ? seq_reg - CW'(1) : seq_reg;

    // Next state and result for the request at the input.
    always_comb begin
        coil_next   = coil_reg;
        moving_next = moving_reg;
        dir_next    = dir_reg;
        mode_next   = mode_reg;
        beat_next   = beat_reg;
        seq_next    = seq_reg;
        timer_next  = timer_reg;
        done        = 1'b0;
        rej         = 1'b0;
        unique case (s_data.cmd)
            CMD_START: begin
                if (moving_reg) begin
                    rej = 1'b1;
                end else if (s_data.drive_mode == MODE_NONE || count == '0) begin
                    done = 1'b1;
                end else begin
                    moving_next = 1'b1;
                    dir_next    = s_data.direction;
                    mode_next   = s_data.drive_mode;
                    beat_next   = '0;
                    seq_next    = count;
                    coil_next   = beat_pattern(s_data.drive_mode, s_data.direction, '0);
                    timer_next  = held;
                end
            end
            CMD_STOP: begin
                coil_next   = '0;
                moving_next = 1'b0;
                beat_next   = '0;
                seq_next    = '0;
                timer_next  = '0;
            end
            CMD_TICK: begin
                if (moving_reg) begin
                    timer_next = timer_dec;
                    if (timer_dec == '0) begin
                        seq_next = seq_dec;
                        if (seq_dec == '0) begin
                            moving_next = 1'b0;
                            beat_next   = '0;
                            done        = 1'b1;
                        end else begin
                            beat_next  = wrap ? '0 : beat_reg + BEAT_W'(1);
                            coil_next  = beat_pattern(mode_reg, dir_reg,
                                                      wrap ? '0 : beat_reg + BEAT_W'(1));
                            timer_next = held;
                        end
                    end
                end
            end
            default: begin
                // Unknown command: status is reported unchanged.
            end
        endcase
        res_next.coils    = coil_next;
        res_next.busy_res = moving_next;
        res_next.done_res = done;
        res_next.rejected = rej;
    end

    // Delay register and control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delay_reg   <= DELAY_RESET;
            coil_reg    <= '0;
            moving_reg  <= 1'b0;
            dir_reg     <= 1'b0;
            mode_reg    <= MODE_HALF;
            beat_reg    <= '0;
            seq_reg     <= '0;
            timer_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                delay_reg <= cfg_wdata;
            end
            if (accept) begin
                coil_reg   <= coil_next;
                moving_reg <= moving_next;
                dir_reg    <= dir_next;
                mode_reg   <= mode_next;
                beat_reg   <= beat_next;
                seq_reg    <= seq_next;
                timer_reg  <= timer_next;
            end
            if (s_ready) begin
                m_valid_reg <= s_valid;
            end
        end
    end

    // Result payload register.
    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= res_next;
        end
    end

endmodule

`default_nettype wire

// ===== bench/sps_checker.sv =====
// Result checker for the stepper phase sequencer: predicts every result and compares it.
`timescale 1ns / 100ps

module sps_checker #(
    parameter int SEQ_W = sps_pkg::SEQ_COUNT_WIDTH_DEF
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        cfg_we,
    input  wire logic [sps_pkg::DELAY_W-1:0] cfg_wdata,
    input  wire logic                        s_valid,
    input  wire logic                        s_ready,
    input  wire sps_pkg::sps_in_t            s_data,
    input  wire logic                        m_valid,
    input  wire logic                        m_ready,
    input  wire sps_pkg::sps_out_t           m_data,
    output int                               fail_count,
    output int                               outstanding
);

    import sps_pkg::*;

    // Forward beat orders, one nibble per beat, beat 0 in the low nibble.
    localparam logic [31:0] HALF_ORDER = 32'h98C46231;
    localparam logic [31:0] WAVE_ORDER = 32'h00008421;
    localparam logic [31:0] TWO_ORDER  = 32'h0000C639;
    localparam longint unsigned SEQ_MAX = (64'd1 << SEQ_W) - 64'd1;

    // Predicted sequencer state.
    logic [DELAY_W-1:0] beat_delay;
    logic [3:0]         coil_drive;
    logic               in_motion;
    logic               run_dir;
    logic [1:0]         run_mode;
    logic [3:0]         beat_pos;
    logic [SEQ_W-1:0]   seq_remaining;
    logic [7:0]         hold_count;

    // Results predicted for accepted requests, oldest first.
    sps_out_t coil_results_q[$];

    initial fail_count = 0;

    function automatic int beats_per_seq(input logic [1:0] mode);
        return (mode == MODE_HALF) ? 8 : 4;
    endfunction

    // Coil pattern at a position in playing order; reverse mirrors the position.
    function automatic logic [3:0] pattern_at(input logic [1:0] mode, input logic dir,
                                              input logic [3:0] pos);
        int          n;
        int          k;
        logic [31:0] order;
        n = beats_per_seq(mode);
        k = int'(pos) % n;
        if (!dir) k = n - 1 - k;
        case (mode)
            MODE_HALF: order = HALF_ORDER;
            MODE_WAVE: order = WAVE_ORDER;
            default:   order = TWO_ORDER;
        endcase
        return order[4*k +: 4];
    endfunction

    // A delay of zero holds each beat for one tick.
    function automatic logic [7:0] reload_ticks();
        return (beat_delay == '0) ? 8'd1 : beat_delay;
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
        fail_count++;
    endtask

    // Applies one request to the predicted state and forms its result.
    task automatic advance_sequencer(input sps_in_t req, output sps_out_t res);
        longint unsigned seq_total;
        int              next_pos;
        logic            done;
        logic            rej;
        done = 1'b0;
        rej  = 1'b0;
        case (req.cmd)
            CMD_START: begin
                if (in_motion) begin
                    rej = 1'b1;
                end else begin
                    seq_total = 64'(req.angle_deg);
                    seq_total = (seq_total * 64) / 45;
                    if (seq_total > SEQ_MAX) seq_total = SEQ_MAX;
                    if (req.drive_mode == MODE_NONE || seq_total == 0) begin
                        done = 1'b1;
                    end else begin
                        in_motion     = 1'b1;
                        run_dir       = req.direction;
                        run_mode      = req.drive_mode;
                        beat_pos      = 4'd0;
                        seq_remaining = seq_total[SEQ_W-1:0];
                        coil_drive    = pattern_at(req.drive_mode, req.direction, 4'd0);
                        hold_count    = reload_ticks();
                    end
                end
            end
            CMD_STOP: begin
                coil_drive    = 4'd0;
                in_motion     = 1'b0;
                beat_pos      = 4'd0;
                seq_remaining = '0;
                hold_count    = 8'd0;
            end
            CMD_TICK: begin
                if (in_motion) begin
                    if (hold_count > 0) hold_count--;
                    if (hold_count == 0) begin
                        next_pos = int'(beat_pos) + 1;
                        if (next_pos >= beats_per_seq(run_mode)) begin
                            next_pos = 0;
                            if (seq_remaining > 0) seq_remaining--;
                        end
                        if (seq_remaining == 0) begin
                            in_motion = 1'b0;
                            beat_pos  = 4'd0;
                            done      = 1'b1;
                        end else begin
                            beat_pos   = 4'(next_pos);
                            coil_drive = pattern_at(run_mode, run_dir, beat_pos);
                            hold_count = reload_ticks();
                        end
                    end
                end
            end
            default: ;
        endcase
        res.coils    = coil_drive;
        res.busy_res = in_motion;
        res.done_res = done;
        res.rejected = rej;
    endtask

    // Watch both channels: compare each taken result, then predict each taken request.
    always @(posedge aclk) begin : watch_channels
        sps_out_t predicted;
        sps_out_t want;
        if (!aresetn) begin
            beat_delay    = DELAY_RESET;
            coil_drive    = 4'd0;
            in_motion     = 1'b0;
            run_dir       = 1'b0;
            run_mode      = MODE_HALF;
            beat_pos      = 4'd0;
            seq_remaining = '0;
            hold_count    = 8'd0;
            coil_results_q.delete();
        end else begin
            if (cfg_we) beat_delay = cfg_wdata;
            if (m_valid && m_ready) begin
                if (coil_results_q.size() == 0) begin
                    report_mismatch("result with no request pending", 16'(m_data), 16'd0);
                end else begin
                    want = coil_results_q.pop_front();
                    if (m_data.coils !== want.coils)
                        report_mismatch("coils", 16'(m_data.coils), 16'(want.coils));
                    if (m_data.busy_res !== want.busy_res)
                        report_mismatch("busy_res", 16'(m_data.busy_res), 16'(want.busy_res));
                    if (m_data.done_res !== want.done_res)
                        report_mismatch("done_res", 16'(m_data.done_res), 16'(want.done_res));
                    if (m_data.rejected !== want.rejected)
                        report_mismatch("rejected", 16'(m_data.rejected), 16'(want.rejected));
                end
            end
            if (s_valid && s_ready) begin
                advance_sequencer(s_data, predicted);
                coil_results_q.push_back(predicted);
            end
        end
        outstanding <= coil_results_q.size();
    end

endmodule

// ===== bench/tb.sv =====
// Testbench top for the stepper phase sequencer: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb;
    import sps_pkg::*;

    localparam int         SEQ_W       = 16;
    localparam int         CYCLE_LIMIT = 400000;
    localparam int         HOLD_CYCLES = 50;
    localparam logic [1:0] CMD_UNUSED  = 2'd3;

    logic               aclk      = 1'b0;
    logic               aresetn   = 1'b0;
    logic               cfg_we    = 1'b0;
    logic [DELAY_W-1:0] cfg_wdata = '0;
    logic               s_valid   = 1'b0;
    logic               s_ready;
    sps_in_t            s_data    = '0;
    logic               m_valid;
    logic               m_ready   = 1'b0;
    sps_out_t           m_data;
    int                 fail_count;
    int                 outstanding;
    int                 cycle_count = 0;
    bit                 idle_on      = 1'b1;
    bit                 hold_off_req = 1'b0;

    always #5 aclk = ~aclk;

    stepper_phase_sequencer #(
        .SEQ_COUNT_WIDTH(SEQ_W)
    ) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    sps_checker #(
        .SEQ_W(SEQ_W)
    ) u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    function automatic sps_in_t make_req(input logic [1:0] cmd, input logic dir,
                                         input logic [1:0] mode, input logic [15:0] angle);
        sps_in_t req;
        req.cmd        = cmd;
        req.direction  = dir;
        req.drive_mode = mode;
        req.angle_deg  = angle;
        return req;
    endfunction

    // Mostly ticks, with starts of short moves; long and saturated moves end by stops.
    function automatic sps_in_t random_request();
        int          pick;
        int          span;
        logic [1:0]  cmd;
        logic [15:0] angle;
        pick = $urandom_range(0, 99);
        if (pick < 70)      cmd = CMD_TICK;
        else if (pick < 86) cmd = CMD_START;
        else if (pick < 93) cmd = CMD_STOP;
        else                cmd = CMD_UNUSED;
        span = $urandom_range(0, 9);
        if (span == 0)      angle = 16'd0;
        else if (span <= 6) angle = 16'($urandom_range(1, 3));
        else if (span == 7) angle = 16'($urandom_range(4, 12));
        else if (span == 8) angle = 16'($urandom);
        else                angle = 16'hFFFF;
        return make_req(cmd, 1'($urandom), 2'($urandom), angle);
    endfunction

    // Offer one request, with an occasional gap first, and wait until it is taken.
    task automatic send_request(input sps_in_t req);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic run_random(input int count);
        repeat (count) send_request(random_request());
    endtask

    // Stop offering and wait until every predicted result has been taken.
    task automatic wait_all_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
    endtask

    task automatic write_delay(input logic [DELAY_W-1:0] value);
        wait_all_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    // Result side: random stalls, plus one long hold-off on request.
    initial begin : result_side
        int held;
        forever begin
            @(posedge aclk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_ready <= 1'b0;
                for (held = 0; held < HOLD_CYCLES; held++) @(posedge aclk);
                m_ready <= 1'b1;
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Run limit.
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("TEST FAILED");
        $finish;
    end

    initial begin : stimulus
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part at the reset delay: idle tick, unknown command, instant finishes,
        // a start while busy and a stop that aborts.
        send_request(make_req(CMD_TICK, 1'b1, MODE_HALF, 16'd0));
        send_request(make_req(CMD_UNUSED, 1'b0, MODE_WAVE, 16'hFFFF));
        send_request(make_req(CMD_START, 1'b1, MODE_NONE, 16'd10));
        send_request(make_req(CMD_START, 1'b0, MODE_HALF, 16'd0));
        send_request(make_req(CMD_START, 1'b1, MODE_HALF, 16'd1));
        send_request(make_req(CMD_START, 1'b0, MODE_TWO, 16'd5));
        send_request(make_req(CMD_STOP, 1'b0, MODE_HALF, 16'd0));

        // Zero delay: one beat per tick; a full half-step sequence runs to its end.
        write_delay(8'd0);
        send_request(make_req(CMD_START, 1'b1, MODE_HALF, 16'd1));
        repeat (8) send_request(make_req(CMD_TICK, 1'b0, MODE_NONE, 16'd0));
        send_request(make_req(CMD_START, 1'b0, MODE_WAVE, 16'd1));
        repeat (2) send_request(make_req(CMD_TICK, 1'b1, MODE_TWO, 16'd0));
        send_request(make_req(CMD_STOP, 1'b1, MODE_NONE, 16'hFFFF));
        // Saturated sequence count, then abort.
        send_request(make_req(CMD_START, 1'b1, MODE_TWO, 16'hFFFF));
        send_request(make_req(CMD_STOP, 1'b0, MODE_HALF, 16'd0));
        send_request(make_req(CMD_START, 1'b0, MODE_TWO, 16'd1));
        repeat (4) send_request(make_req(CMD_TICK, 1'b0, MODE_HALF, 16'd0));

        // Long hold-off on the result side while requests keep coming.
        write_delay(8'd1);
        idle_on      = 1'b0;
        hold_off_req = 1'b1;
        run_random(24);
        idle_on = 1'b1;
        wait_all_results();
        run_random(300);

        write_delay(8'd3);
        run_random(300);

        // Largest delay: a move is held on each beat for a long time.
        write_delay(8'd255);
        send_request(make_req(CMD_START, 1'b1, MODE_WAVE, 16'd1));
        run_random(300);

        write_delay(8'd0);
        run_random(300);

        write_delay(8'($urandom_range(2, 6)));
        run_random(300);

        // Closing stretch without idling on either side.
        write_delay(8'd1);
        idle_on = 1'b0;
        run_random(300);

        wait_all_results();
        repeat (3) @(posedge aclk);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/sps_pkg.sv
rtl/core/stepper_phase_sequencer.sv
bench/sps_checker.sv
bench/tb.sv
